// ===== rtl/core/rtpdd_pkg.sv =====
package rtpdd_pkg;

   typedef enum logic [2:0] {
      PH_WRAP  = 3'd0,
      PH_DHDR  = 3'd1,
      PH_BODY  = 3'd2,
      PH_TRAIL = 3'd3,
      PH_HALT  = 3'd4
   } phase_type;

   localparam logic [1:0] KIND_PACKET = 2'd0;
   localparam logic [1:0] KIND_UNIT   = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ERR_WRAPPER  = 3'd1;
   localparam logic [2:0] ERR_DUMP_HDR = 3'd2;
   localparam logic [2:0] ERR_TOO_LONG = 3'd3;
   localparam logic [2:0] ERR_LEFTOVER = 3'd4;
   localparam logic [2:0] ERR_TRAILER  = 3'd5;

   localparam logic [63:0] TS_OFFSET    = 64'h2B61082F0 * 64'd10000000;
   localparam logic [7:0]  WRAP_MARK_A  = 8'h80;
   localparam logic [7:0]  WRAP_MARK_B  = 8'h30;
   localparam logic [31:0] RECIP_HI     = 32'hCCCC_CCCC;
   localparam logic [31:0] RECIP_LO     = 32'hCCCC_CCCD;

endpackage

// ===== rtl/core/rtp_dump_unit_deframer_top.sv =====
// A result is registered and appears on rsp_ in the cycle after the byte transfer that causes it.
// Throughput: one byte per cycle; req_ready drops only while a result waits for rsp_ready.
// The timestamp conversion multiplies by the reciprocal of ten, one 32 by 32 partial
// product per cycle, started by the last timestamp byte and hidden behind the wrapper
// header.
// Reset (synchronous, active high) returns to the wrapper header, clears the halt
// and loads stream_type with 31.
module rtp_dump_unit_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_stream_type,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [63:0] rsp_pts,
   output logic        rsp_pts_valid,
   output logic        rsp_random_access,
   output logic        rsp_hidden,
   output logic [15:0] rsp_payload_offset,
   output logic [15:0] rsp_payload_length,
   output logic        rsp_marker,
   output logic        rsp_packet_ok,
   output logic [2:0]  rsp_error_code
);
   import rtpdd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [31:0] unit_size_ff, unit_size_in;
   logic [31:0] remain_ff, remain_in;
   logic [63:0] raw_ts_ff, raw_ts_in;
   logic [7:0]  flags_ff, flags_in;
   logic [15:0] pkt_size_ff, pkt_size_in;
   logic [15:0] rtp_hdr_ff, rtp_hdr_in;
   logic [15:0] ext_len_ff, ext_len_in;
   logic [31:0] trailer_ff, trailer_in;
   logic [7:0]  stream_type_ff;

   logic         div_busy_ff;
   logic [1:0]   div_step_ff;
   logic [63:0]  div_num_ff;
   logic [127:0] div_acc_ff;
   logic         div_start;
   logic [63:0]  div_start_val;
   logic [31:0]  mul_a, mul_b;
   logic [63:0]  mul_p;
   logic [127:0] mul_term;

   logic        rsp_valid_ff;
   logic [1:0]  kind_ff;
   logic [63:0] pts_ff;
   logic        pts_valid_ff, ra_ff, hidden_ff, marker_ff, ok_ff;
   logic [15:0] off_ff, len_ff;
   logic [2:0]  err_ff;

   logic        acc;
   logic        res_in, unit_in, marker_in, ok_in;
   logic [1:0]  kind_in;
   logic [2:0]  err_in;
   logic [15:0] off_in, len_in;
   phase_type   ph;
   logic [15:0] idx;
   logic [7:0]  b;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign acc       = req_valid && req_ready;

   always_comb begin
      logic [16:0] rem;
      logic [15:0] start;
      logic [5:0]  cc4;
      logic [17:0] ext4;
      logic        good;
      logic [16:0] pos;
      logic [32:0] need;
      ph            = req_restart ? PH_WRAP : phase_ff;
      idx           = req_restart ? 16'd0 : count_ff;
      b             = req_data_byte;
      phase_in      = phase_ff;
      count_in      = count_ff;
      unit_size_in  = unit_size_ff;
      remain_in     = remain_ff;
      raw_ts_in     = raw_ts_ff;
      flags_in      = flags_ff;
      pkt_size_in   = pkt_size_ff;
      rtp_hdr_in    = rtp_hdr_ff;
      ext_len_in    = ext_len_ff;
      trailer_in    = trailer_ff;
      res_in        = 1'b0;
      unit_in       = 1'b0;
      marker_in     = 1'b0;
      ok_in         = 1'b0;
      kind_in       = KIND_PACKET;
      err_in        = 3'd0;
      off_in        = 16'd0;
      len_in        = 16'd0;
      div_start     = 1'b0;
      div_start_val = 64'd0;
      rem           = 17'd0;
      start         = 16'd12;
      cc4           = 6'd0;
      ext4          = 18'd0;
      good          = 1'b0;
      pos           = 17'd0;
      need          = 33'd0;
      if (acc) begin
         case (ph)
            PH_WRAP: begin
               count_in = idx + 16'd1;
               phase_in = PH_WRAP;
               if (idx < 16'd8) begin
                  if (idx == 16'd0) begin
                     raw_ts_in = {56'd0, b};
                  end else begin
                     raw_ts_in[{idx[2:0], 3'b000} +: 8] = b;
                  end
                  if (idx == 16'd7) begin
                     div_start     = 1'b1;
                     div_start_val = {b, raw_ts_ff[55:0]} - TS_OFFSET;
                  end
               end else if (idx == 16'd8) begin
                  flags_in = b;
               end else if (idx <= 16'd12) begin
                  if (idx == 16'd9) begin
                     unit_size_in = {24'd0, b};
                  end else begin
                     unit_size_in[{idx[1:0] - 2'd1, 3'b000} +: 8] = b;
                  end
               end else if (idx == 16'd13) begin
                  if (b != WRAP_MARK_A) begin
                     res_in   = 1'b1;
                     kind_in  = KIND_ERROR;
                     err_in   = ERR_WRAPPER;
                     phase_in = PH_HALT;
                     count_in = 16'd0;
                  end
               end else if (idx >= 16'd24) begin
                  count_in = 16'd0;
                  if (b != WRAP_MARK_B || unit_size_ff < 32'd12) begin
                     res_in   = 1'b1;
                     kind_in  = KIND_ERROR;
                     err_in   = ERR_WRAPPER;
                     phase_in = PH_HALT;
                  end else begin
                     remain_in = unit_size_ff - 32'd12;
                     phase_in  = (remain_in == 32'd0) ? PH_TRAIL : PH_DHDR;
                  end
               end
            end
            PH_DHDR: begin
               count_in = idx + 16'd1;
               if (idx == 16'd0) begin
                  if (remain_ff < 32'd6) begin
                     res_in  = 1'b1;
                     err_in  = ERR_LEFTOVER;
                  end else if (b != 8'd0) begin
                     res_in  = 1'b1;
                     err_in  = ERR_DUMP_HDR;
                  end
               end else if (idx == 16'd1) begin
                  if (b != stream_type_ff) begin
                     res_in = 1'b1;
                     err_in = ERR_DUMP_HDR;
                  end
               end else if (idx == 16'd2) begin
                  pkt_size_in = {b, 8'd0};
               end else if (idx == 16'd3) begin
                  pkt_size_in = {pkt_size_ff[15:8], b};
                  need        = {17'd0, pkt_size_in} + 33'd6;
                  if (need > {1'b0, remain_ff}) begin
                     res_in = 1'b1;
                     err_in = ERR_TOO_LONG;
                  end
               end else if (idx >= 16'd5) begin
                  count_in = 16'd0;
                  if (pkt_size_ff == 16'd0) begin
                     remain_in = remain_ff - 32'd6;
                     res_in    = 1'b1;
                     unit_in   = 1'b1;
                     phase_in  = (remain_in == 32'd0) ? PH_TRAIL : PH_DHDR;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
               if (res_in && err_in != 3'd0) begin
                  kind_in  = KIND_ERROR;
                  phase_in = PH_HALT;
                  count_in = 16'd0;
               end
            end
            PH_BODY: begin
               count_in = idx + 16'd1;
               if (idx == 16'd0) begin
                  rtp_hdr_in = {b, 8'd0};
               end else if (idx == 16'd1) begin
                  rtp_hdr_in = {rtp_hdr_ff[15:8], b};
               end
               pos = 17'd14 + {11'd0, rtp_hdr_in[11:8], 2'b00};
               if ({1'b0, idx} == pos) begin
                  ext_len_in = {b, 8'd0};
               end else if ({1'b0, idx} == pos + 17'd1) begin
                  ext_len_in = {ext_len_ff[15:8], b};
               end
               if ({1'b0, idx} + 17'd1 >= {1'b0, pkt_size_ff}) begin
                  res_in    = 1'b1;
                  unit_in   = 1'b1;
                  marker_in = rtp_hdr_in[7];
                  if (pkt_size_ff >= 16'd12 && rtp_hdr_in[15:14] == 2'b10) begin
                     good = 1'b1;
                     rem  = {1'b0, pkt_size_ff} - 17'd12;
                     if (rtp_hdr_in[13]) begin
                        if (rem < 17'd2 || b == 8'd0 || {9'd0, b} >= rem) begin
                           good = 1'b0;
                        end else begin
                           rem = rem - {9'd0, b};
                        end
                     end
                     if (good) begin
                        cc4 = {rtp_hdr_in[11:8], 2'b00};
                        if ({11'd0, cc4} > rem) begin
                           good = 1'b0;
                        end else begin
                           start = start + {10'd0, cc4};
                           rem   = rem - {11'd0, cc4};
                        end
                     end
                     if (good && rtp_hdr_in[12]) begin
                        ext4 = {ext_len_in, 2'b00};
                        if (rem < 17'd4 || ext4 > {1'b0, rem} - 18'd4) begin
                           good = 1'b0;
                        end else begin
                           start = start + 16'd4 + ext4[15:0];
                           rem   = rem - 17'd4 - ext4[16:0];
                        end
                     end
                  end
                  if (good) begin
                     off_in = start;
                     len_in = rem[15:0];
                     ok_in  = 1'b1;
                  end
                  remain_in = remain_ff - 32'd6 - {16'd0, pkt_size_ff};
                  phase_in  = (remain_in == 32'd0) ? PH_TRAIL : PH_DHDR;
                  count_in  = 16'd0;
               end
            end
            PH_TRAIL: begin
               count_in = idx + 16'd1;
               if (idx == 16'd0) begin
                  trailer_in = {24'd0, b};
               end else begin
                  trailer_in[{idx[1:0], 3'b000} +: 8] = b;
               end
               if (idx >= 16'd3) begin
                  res_in   = 1'b1;
                  count_in = 16'd0;
                  if (trailer_in != unit_size_ff + 32'd13) begin
                     kind_in  = KIND_ERROR;
                     err_in   = ERR_TRAILER;
                     phase_in = PH_HALT;
                  end else begin
                     kind_in  = KIND_UNIT;
                     unit_in  = 1'b1;
                     phase_in = PH_WRAP;
                  end
               end
            end
            default: begin
               phase_in = ph;
               count_in = idx;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_WRAP;
         count_ff       <= 16'd0;
         unit_size_ff   <= 32'd0;
         remain_ff      <= 32'd0;
         raw_ts_ff      <= 64'd0;
         flags_ff       <= 8'd0;
         pkt_size_ff    <= 16'd0;
         rtp_hdr_ff     <= 16'd0;
         ext_len_ff     <= 16'd0;
         trailer_ff     <= 32'd0;
         stream_type_ff <= 8'd31;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         unit_size_ff <= unit_size_in;
         remain_ff    <= remain_in;
         raw_ts_ff    <= raw_ts_in;
         flags_ff     <= flags_in;
         pkt_size_ff  <= pkt_size_in;
         rtp_hdr_ff   <= rtp_hdr_in;
         ext_len_ff   <= ext_len_in;
         trailer_ff   <= trailer_in;
         if (csr_valid) begin
            stream_type_ff <= csr_stream_type;
         end
      end
   end

   always_comb begin
      mul_a = div_step_ff[1] ? div_num_ff[63:32] : div_num_ff[31:0];
      mul_b = div_step_ff[0] ? RECIP_HI : RECIP_LO;
      mul_p = {32'd0, mul_a} * {32'd0, mul_b};
      case (div_step_ff)
         2'd0:    mul_term = {64'd0, mul_p};
         2'd3:    mul_term = {mul_p, 64'd0};
         default: mul_term = {32'd0, mul_p, 32'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_step_ff <= 2'd0;
      end else if (div_start) begin
         div_busy_ff <= 1'b1;
         div_step_ff <= 2'd0;
      end else if (div_busy_ff) begin
         div_step_ff <= div_step_ff + 2'd1;
         div_busy_ff <= (div_step_ff != 2'd3);
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         div_num_ff <= div_start_val;
         div_acc_ff <= 128'd0;
      end else if (div_busy_ff) begin
         div_acc_ff <= div_acc_ff + mul_term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (acc && res_in) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc && res_in) begin
         kind_ff      <= kind_in;
         err_ff       <= err_in;
         off_ff       <= off_in;
         len_ff       <= len_in;
         marker_ff    <= marker_in;
         ok_ff        <= ok_in;
         if (unit_in && raw_ts_ff != 64'hFFFF_FFFF_FFFF_FFFF) begin
            pts_ff       <= {3'd0, div_acc_ff[127:67]} + 64'd1;
            pts_valid_ff <= 1'b1;
         end else begin
            pts_ff       <= 64'd0;
            pts_valid_ff <= 1'b0;
         end
         ra_ff        <= unit_in & flags_ff[2];
         hidden_ff    <= unit_in & flags_ff[0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_pts            = pts_ff;
   assign rsp_pts_valid      = pts_valid_ff;
   assign rsp_random_access  = ra_ff;
   assign rsp_hidden         = hidden_ff;
   assign rsp_payload_offset = off_ff;
   assign rsp_payload_length = len_ff;
   assign rsp_marker         = marker_ff;
   assign rsp_packet_ok      = ok_ff;
   assign rsp_error_code     = err_ff;

   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (acc && res_in && kind_in == KIND_ERROR) |=> phase_ff == PH_HALT)
      else $error("error transfer did not halt");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (acc && ph == PH_WRAP && idx >= 16'd24) |-> !div_busy_ff)
      else $error("timestamp conversion still running at wrapper end");

   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      (acc && ph == PH_HALT) |-> !res_in)
      else $error("result while halted");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_pts))
      else $error("result changed while stalled");

endmodule

// ===== tb/rtp_dump_unit_deframer_top_test.sv =====
module rtp_dump_unit_deframer_top_test;
   import rtpdd_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] pts;
      logic        pts_valid;
      logic        random_access;
      logic        hidden;
      logic [15:0] payload_offset;
      logic [15:0] payload_length;
      logic        marker;
      logic        packet_ok;
      logic [2:0]  error_code;
   } deframe_result_type;

   class deframe_scoreboard;
      logic [7:0]  stream_type;
      phase_type   phase;
      int unsigned sec_idx;
      logic [31:0] unit_size;
      logic [31:0] remaining;
      logic [63:0] raw_ts;
      logic [7:0]  flags;
      logic [15:0] pkt_size;
      logic [15:0] rtp_head;
      logic [15:0] ext_len;
      logic [31:0] trailer;
      deframe_result_type pending_q[$];
      int mismatches;

      function new();
         stream_type = 8'd31;
         phase = PH_WRAP;
         sec_idx = 0;
         unit_size = 0;
         remaining = 0;
         raw_ts = 0;
         flags = 0;
         pkt_size = 0;
         rtp_head = 0;
         ext_len = 0;
         trailer = 0;
         mismatches = 0;
      endfunction

      function deframe_result_type unit_info(logic [1:0] k);
         deframe_result_type r;
         r = '0;
         r.kind = k;
         if (raw_ts != 64'hFFFF_FFFF_FFFF_FFFF) begin
            r.pts = 64'd1 + (raw_ts - TS_OFFSET) / 64'd10;
            r.pts_valid = 1'b1;
         end
         r.random_access = flags[2];
         r.hidden = flags[0];
         return r;
      endfunction

      function void raise_error(logic [2:0] code);
         deframe_result_type r;
         r = '0;
         r.kind = KIND_ERROR;
         r.error_code = code;
         pending_q.push_back(r);
         phase = PH_HALT;
         sec_idx = 0;
      endfunction

      function void end_section();
         phase = (remaining == 0) ? PH_TRAIL : PH_DHDR;
         sec_idx = 0;
      endfunction

      function void describe_packet(logic [7:0] last);
         deframe_result_type r;
         int unsigned len, start, rest, cc4, e;
         bit ok;
         len = pkt_size;
         start = 12;
         rest = 0;
         ok = 0;
         r = unit_info(KIND_PACKET);
         r.marker = rtp_head[7];
         if (len >= 12 && rtp_head[15:14] == 2'd2) begin
            ok = 1;
            rest = len - 12;
            if (rtp_head[13]) begin
               if (rest < 2 || last == 0 || last >= rest) ok = 0;
               else rest -= last;
            end
            if (ok) begin
               cc4 = rtp_head[11:8] * 4;
               if (cc4 > rest) ok = 0;
               else begin
                  start += cc4;
                  rest -= cc4;
               end
            end
            if (ok && rtp_head[12]) begin
               e = ext_len * 4;
               if (rest < 4 || e > rest - 4) ok = 0;
               else begin
                  start += 4 + e;
                  rest -= 4 + e;
               end
            end
         end
         if (ok) begin
            r.payload_offset = start[15:0];
            r.payload_length = rest[15:0];
            r.packet_ok = 1'b1;
         end
         pending_q.push_back(r);
      endfunction

      function void note_byte(logic [7:0] b, logic rst);
         int unsigned i, pos;
         if (rst) begin
            phase = PH_WRAP;
            sec_idx = 0;
         end
         i = sec_idx;
         case (phase)
            PH_WRAP: begin
               if (i < 8) begin
                  if (i == 0) raw_ts = {56'd0, b};
                  else raw_ts[8*i +: 8] = b;
               end else if (i == 8) flags = b;
               else if (i <= 12) begin
                  if (i == 9) unit_size = {24'd0, b};
                  else unit_size[8*(i-9) +: 8] = b;
               end else if (i == 13) begin
                  if (b != WRAP_MARK_A) begin
                     raise_error(ERR_WRAPPER);
                     return;
                  end
               end else if (i >= 24) begin
                  if (b != WRAP_MARK_B || unit_size < 12) begin
                     raise_error(ERR_WRAPPER);
                     return;
                  end
                  remaining = unit_size - 12;
                  end_section();
                  return;
               end
               sec_idx = i + 1;
            end
            PH_DHDR: begin
               if (i == 0) begin
                  if (remaining < 6) begin
                     raise_error(ERR_LEFTOVER);
                     return;
                  end
                  if (b != 0) begin
                     raise_error(ERR_DUMP_HDR);
                     return;
                  end
               end else if (i == 1) begin
                  if (b != stream_type) begin
                     raise_error(ERR_DUMP_HDR);
                     return;
                  end
               end else if (i == 2) pkt_size = {b, 8'd0};
               else if (i == 3) begin
                  pkt_size[7:0] = b;
                  if ({16'd0, pkt_size} + 32'd6 > remaining) begin
                     raise_error(ERR_TOO_LONG);
                     return;
                  end
               end else if (i >= 5) begin
                  if (pkt_size == 0) begin
                     remaining -= 6;
                     pending_q.push_back(unit_info(KIND_PACKET));
                     end_section();
                     return;
                  end
                  phase = PH_BODY;
                  sec_idx = 0;
                  return;
               end
               sec_idx = i + 1;
            end
            PH_BODY: begin
               if (i == 0) rtp_head = {b, 8'd0};
               else if (i == 1) rtp_head[7:0] = b;
               pos = 14 + rtp_head[11:8] * 4;
               if (i == pos) ext_len = {b, 8'd0};
               else if (i == pos + 1) ext_len[7:0] = b;
               if (i + 1 >= pkt_size) begin
                  describe_packet(b);
                  remaining -= 6 + pkt_size;
                  end_section();
                  return;
               end
               sec_idx = i + 1;
            end
            PH_TRAIL: begin
               if (i == 0) trailer = {24'd0, b};
               else trailer[8*(i%4) +: 8] = b;
               if (i >= 3) begin
                  if (trailer != unit_size + 32'd13) begin
                     raise_error(ERR_TRAILER);
                     return;
                  end
                  pending_q.push_back(unit_info(KIND_UNIT));
                  phase = PH_WRAP;
                  sec_idx = 0;
                  return;
               end
               sec_idx = i + 1;
            end
            default: ;
         endcase
      endfunction

      function void check_result(deframe_result_type got);
         deframe_result_type want;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         want = pending_q.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass

   logic clock, reset;
   logic csr_valid, csr_ready;
   logic [7:0] csr_stream_type;
   logic req_valid, req_ready;
   logic [7:0] req_data_byte;
   logic req_restart;
   logic rsp_valid, rsp_ready;
   logic [1:0] rsp_kind;
   logic [63:0] rsp_pts;
   logic rsp_pts_valid, rsp_random_access, rsp_hidden;
   logic [15:0] rsp_payload_offset, rsp_payload_length;
   logic rsp_marker, rsp_packet_ok;
   logic [2:0] rsp_error_code;

   deframe_scoreboard sb;
   int idle_pct;
   int stall_cycles;
   bit timed_out;
   int sent;
   byte unsigned unit_q[$];

   rtp_dump_unit_deframer_top i_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result({rsp_kind, rsp_pts, rsp_pts_valid, rsp_random_access, rsp_hidden,
                             rsp_payload_offset, rsp_payload_length, rsp_marker,
                             rsp_packet_ok, rsp_error_code});
         rsp_ready <= ($urandom_range(99) >= idle_pct);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (stall_cycles > 5000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic rst);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_restart <= rst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(b, rst);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_type(input logic [7:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_stream_type <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.stream_type = v;
      csr_valid <= 1'b0;
   endtask

   // Build one wrapper unit into unit_q; corrupt selects an optional defect.
   task automatic build_unit(input int npk, input int corrupt);
      byte unsigned body[$];
      logic [63:0] ts;
      logic [31:0] sz;
      int len, k, cc, x, pad;
      logic [7:0] b0;
      body = {};
      for (int p = 0; p < npk; p++) begin
         case ($urandom_range(5))
            0: len = 0;
            1: len = $urandom_range(11);
            default: len = $urandom_range(12, 40);
         endcase
         body.push_back(8'd0);
         body.push_back((corrupt == 2 && p == 0) ? sb.stream_type + 8'd1 : sb.stream_type);
         body.push_back(8'(len >> 8));
         body.push_back(8'(len));
         body.push_back(8'($urandom));
         body.push_back(8'($urandom));
         cc = $urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(2);
         x = $urandom_range(1);
         pad = int'($urandom_range(3) == 0);
         b0 = ($urandom_range(7) == 0) ? 8'($urandom) : {2'b10, pad[0], x[0], cc[3:0]};
         for (k = 0; k < len; k++) begin
            if (k == 0) body.push_back(b0);
            else if (k == 14 + cc * 4) body.push_back(8'd0);
            else if (k == 15 + cc * 4) body.push_back(8'($urandom_range(3)));
            else if (k == len - 1 && pad != 0) body.push_back(8'($urandom_range(8)));
            else body.push_back(8'($urandom));
         end
      end
      if (corrupt == 4) repeat ($urandom_range(1, 5)) body.push_back(8'd0);
      ts = ($urandom_range(7) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF :
           ($urandom_range(3) == 0) ? {$urandom, $urandom} :
           TS_OFFSET + {32'd0, $urandom};
      sz = 32'(body.size()) + 32'd12;
      if (corrupt == 3) sz = sz + 32'd40;
      unit_q = {};
      for (k = 0; k < 8; k++) unit_q.push_back(ts[8*k +: 8]);
      unit_q.push_back(8'($urandom));
      for (k = 0; k < 4; k++) unit_q.push_back(sz[8*k +: 8]);
      unit_q.push_back(corrupt == 1 ? 8'h81 : WRAP_MARK_A);
      for (k = 14; k < 24; k++) unit_q.push_back(8'($urandom));
      unit_q.push_back(corrupt == 6 ? 8'h31 : WRAP_MARK_B);
      foreach (body[k]) unit_q.push_back(body[k]);
      sz = sz + 32'd13 + 32'(corrupt == 5);
      for (k = 0; k < 4; k++) unit_q.push_back(sz[8*k +: 8]);
   endtask

   task automatic send_unit(input int npk, input int corrupt);
      build_unit(npk, corrupt);
      foreach (unit_q[k]) send_byte(unit_q[k], k == 0);
   endtask

   initial begin
      sb = new();
      reset = 1;
      csr_valid = 0;
      csr_stream_type = 0;
      req_valid = 0;
      req_data_byte = 0;
      req_restart = 0;
      rsp_ready = 0;
      idle_pct = 32;
      stall_cycles = 0;
      sent = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      idle_pct = 0;
      send_unit(1, 0);
      send_unit(0, 0);
      for (int c = 1; c <= 6; c++) send_unit(1, c);
      send_byte(8'hFF, 0);
      send_byte(8'h00, 0);
      write_type(8'h00);
      send_unit(2, 0);
      write_type(8'hFF);
      send_unit(2, 0);
      drain();
      idle_pct = 32;

      while (sent < 1750) begin
         if (sent > 900 && sent < 1300) idle_pct = 0;
         else idle_pct = 32;
         if ($urandom_range(9) == 0) write_type(8'($urandom));
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 20)) send_byte(8'($urandom), $urandom_range(7) == 0);
         end else
            send_unit($urandom_range(1, 3), $urandom_range(5) == 0 ? $urandom_range(1, 6) : 0);
      end
      write_type(8'd31);
      send_unit(2, 0);

      drain();
      if (sb.mismatches == 0 && sb.pending_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
